[rtl/rc4_pkg.sv]
// Shared constants and types for the RC4 stream cipher block.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  // Permutation table geometry
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = 8;

  // Default key store depth
  localparam int KEY_DEPTH_DEF = 256;

  // Width of the key length register
  localparam int KEY_LEN_W = 9;

  // Command codes
  localparam logic [1:0] CMD_LOAD_KEY = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_DATA     = 2'd2;

  // One cycle of access to the permutation store
  typedef struct packed {
    logic               wr_en;
    logic [PERM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [PERM_AW-1:0] rd_addr;
    logic               byp_en;
    logic [7:0]         byp_data;
  } perm_req_t;

endpackage

`default_nettype wire

[rtl/rc4_perm_store.sv]
// Permutation table memory with registered read and same-cycle bypass.
`timescale 1ns / 1ps
`default_nettype none

module rc4_perm_store (
  input  wire logic              clk,
  input  wire rc4_pkg::perm_req_t req,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [rc4_pkg::PERM_SIZE];
  logic [7:0] mem_q;
  logic       byp_q;
  logic [7:0] byp_data_q;

  // Write one entry, read one entry; the read sees the old contents
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q      <= mem[req.rd_addr];
      byp_q      <= req.byp_en;
      byp_data_q <= req.byp_data;
    end
  end

  // Replace the stale read when the caller knows the newer value
  assign rd_data = byp_q ? byp_data_q : mem_q;

endmodule

`default_nettype wire

[rtl/rc4_stream_cipher.sv]
// Top level of the RC4 stream cipher: control, index registers and key store.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                          Transfer when
// in        sink       in_valid, in_ready, cmd, value   in_valid & in_ready
// out       source     out_valid, out_ready, out_byte   out_valid & out_ready
// cfg       sink       cfg_valid, cfg_ready, key_length cfg_valid & cfg_ready
//
// A key byte or an unknown command is taken in the accept step alone. A data
// byte walks the chain of permutation reads (S[i], then S[j], then
// S[S[i]+S[j]]) through the single-read-port table, plus the write-back of
// the swap. A key schedule runs the accept step, a pass that fills the table
// with the identity, then per entry the states ST_KS_J, ST_KS_WA and ST_KS_WB
// for read, swap write and swap write with the next read.
// Reset clears indices, key pointer, key length (to 1) and the output flag;
// the memories hold no reset value. A result waiting at the output stalls only
// the final step (ST_D_WB) of the next data byte; input is not taken there.

module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    cmd,
  input  wire logic [7:0]                    value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0] key_length
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = rc4_pkg::KEY_LEN_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(KEY_DEPTH);
  localparam logic [LW-1:0] LAST_L  = LW'(KEY_DEPTH - 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_KS_J  = 9'b000000100,
    ST_KS_WA = 9'b000001000,
    ST_KS_WB = 9'b000010000,
    ST_D_J   = 9'b000100000,
    ST_D_T   = 9'b001000000,
    ST_D_WB  = 9'b010000000,
    ST_SPARE = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [7:0]         idx_i, idx_i_next;
  logic [7:0]         idx_j, idx_j_next;
  logic [KW-1:0]      wptr, wptr_next;
  logic [7:0]         ctr, ctr_next;
  logic [KW-1:0]      kidx, kidx_next;
  logic [7:0]         held, held_next;
  logic [7:0]         data_byte, data_byte_next;
  logic               out_valid_next;
  logic [7:0]         out_byte_next;
  logic [LW-1:0]      key_len;

  logic [7:0]         key_mem [KEY_DEPTH];
  logic [7:0]         key_q;
  logic [KW-1:0]      key_raddr;
  logic [KW-1:0]      kidx_adv;
  logic [LW-1:0]      n_eff;
  logic               key_wr;

  rc4_pkg::perm_req_t preq;
  logic [7:0]         perm_rd;
  logic [7:0]         jsum;
  logic [7:0]         tsum;
  logic [7:0]         ctr_inc;

  rc4_perm_store u_perm (
    .clk     (clk),
    .req     (preq),
    .rd_data (perm_rd)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the key length into 1..KEY_DEPTH
  always_comb begin
    if (key_len == '0) begin
      n_eff = LW'(1);
    end else if (key_len > DEPTH_L) begin
      n_eff = DEPTH_L;
    end else begin
      n_eff = key_len;
    end
  end

  // Step the cyclic key index
  assign kidx_adv  = ((LW'(kidx) + LW'(1)) >= n_eff) ? '0 : KW'(LW'(kidx) + LW'(1));
  assign key_raddr = (state == ST_KS_WB) ? kidx_adv : kidx;
  assign key_wr    = in_valid && in_ready && (cmd == rc4_pkg::CMD_LOAD_KEY);
  assign ctr_inc   = ctr + 8'd1;
  assign jsum      = idx_j + perm_rd + key_q;
  assign tsum      = held + perm_rd;

  // Sequence the commands
  always_comb begin
    state_next     = state;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    wptr_next      = wptr;
    ctr_next       = ctr;
    kidx_next      = kidx;
    held_next      = held;
    data_byte_next = data_byte;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    preq           = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            rc4_pkg::CMD_LOAD_KEY: begin
              wptr_next = (LW'(wptr) == LAST_L) ? '0 : KW'(LW'(wptr) + LW'(1));
            end
            rc4_pkg::CMD_SCHEDULE: begin
              ctr_next   = '0;
              kidx_next  = '0;
              state_next = ST_INIT;
            end
            rc4_pkg::CMD_DATA: begin
              idx_i_next     = idx_i + 8'd1;
              data_byte_next = value;
              preq.rd_en     = 1'b1;
              preq.rd_addr   = idx_i + 8'd1;
              state_next     = ST_D_J;
            end
            default: begin
            end
          endcase
        end
      end

      // Fill the table with the identity; the last cycle reads entry 0
      ST_INIT: begin
        preq.wr_en   = 1'b1;
        preq.wr_addr = ctr;
        preq.wr_data = ctr;
        ctr_next     = ctr_inc;
        if (ctr == 8'hFF) begin
          preq.rd_en   = 1'b1;
          preq.rd_addr = '0;
          idx_j_next   = '0;
          state_next   = ST_KS_J;
        end
      end

      // Advance j with S[k] and the key byte, read S[j]
      ST_KS_J: begin
        held_next    = perm_rd;
        idx_j_next   = jsum;
        preq.rd_en   = 1'b1;
        preq.rd_addr = jsum;
        state_next   = ST_KS_WA;
      end

      ST_KS_WA: begin
        preq.wr_en   = 1'b1;
        preq.wr_addr = ctr;
        preq.wr_data = perm_rd;
        state_next   = ST_KS_WB;
      end

      // Finish the swap and read the next entry, bypassing the write
      ST_KS_WB: begin
        preq.wr_en   = 1'b1;
        preq.wr_addr = idx_j;
        preq.wr_data = held;
        kidx_next    = kidx_adv;
        ctr_next     = ctr_inc;
        if (ctr == 8'hFF) begin
          idx_i_next = '0;
          idx_j_next = '0;
          wptr_next  = '0;
          state_next = ST_IDLE;
        end else begin
          preq.rd_en    = 1'b1;
          preq.rd_addr  = ctr_inc;
          preq.byp_en   = (idx_j == ctr_inc);
          preq.byp_data = held;
          state_next    = ST_KS_J;
        end
      end

      // Advance j with S[i], read S[j]
      ST_D_J: begin
        held_next    = perm_rd;
        idx_j_next   = idx_j + perm_rd;
        preq.rd_en   = 1'b1;
        preq.rd_addr = idx_j + perm_rd;
        state_next   = ST_D_T;
      end

      // Write S[i], read the keystream entry with swap forwarding
      ST_D_T: begin
        preq.wr_en    = 1'b1;
        preq.wr_addr  = idx_i;
        preq.wr_data  = perm_rd;
        preq.rd_en    = 1'b1;
        preq.rd_addr  = tsum;
        preq.byp_en   = (tsum == idx_j) || (tsum == idx_i);
        preq.byp_data = (tsum == idx_j) ? held : perm_rd;
        state_next    = ST_D_WB;
      end

      // Write S[j] and hand out the result once the output is free
      ST_D_WB: begin
        preq.wr_en   = 1'b1;
        preq.wr_addr = idx_j;
        preq.wr_data = held;
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_byte_next  = data_byte ^ perm_rd;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      wptr      <= '0;
      ctr       <= '0;
      kidx      <= '0;
      out_valid <= 1'b0;
      key_len   <= LW'(1);
    end else begin
      state     <= state_next;
      idx_i     <= idx_i_next;
      idx_j     <= idx_j_next;
      wptr      <= wptr_next;
      ctr       <= ctr_next;
      kidx      <= kidx_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        key_len <= key_length;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held      <= held_next;
    data_byte <= data_byte_next;
    out_byte  <= out_byte_next;
  end

  // Key store: written on load, read every cycle for the schedule
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[wptr] <= value;
    end
    key_q <= key_mem[key_raddr];
  end

  // A data byte walks its read chain in order
  a_data_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == rc4_pkg::CMD_DATA)
      |=> (state == ST_D_J) ##1 (state == ST_D_T))
    else $error("data byte left its read sequence");

  // The fill pass hands over to the swap loop with j cleared
  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT && ctr == 8'hFF)
      |=> (state == ST_KS_J && ctr == 8'd0 && idx_j == 8'd0))
    else $error("fill pass did not start the swap loop");

  // The key schedule ends with indices and key pointer cleared
  a_ks_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_WB && ctr == 8'hFF)
      |=> (state == ST_IDLE && idx_i == 8'd0 && idx_j == 8'd0 && wptr == '0))
    else $error("key schedule did not clear its indices");

  // A result appears only from the final data step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_D_WB))
    else $error("result raised outside the final data step");

endmodule

`default_nettype wire
